// ----- hdl/dps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dps_pkg: shared types and constants of the dynamic priority scheduler
// Request and result payloads, table entry layout, status and state codes.
// ----------------------------------------------------------------------------
package dps_pkg;

  // default table depth and reset step
  localparam int unsigned MAX_PROCS_DEF = 8;
  localparam logic [7:0]  PRIO_STEP_RST = 8'd3;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_DONE   = 3'd1,
    ST_IDLE   = 3'd2,
    ST_LOADED = 3'd3,
    ST_FULL   = 3'd4
  } dps_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_UPD,
    S_RESP
  } dps_state_t;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         proc_id;
    logic signed [15:0] start_priority;
    logic [15:0]        start_cpu_time;
    logic [7:0]         need_time;
  } dps_req_t;

  typedef struct packed {
    dps_status_t        status;
    logic [7:0]         run_id;
    logic signed [15:0] new_priority;
    logic [15:0]        new_cpu_time;
    logic [7:0]         remaining;
  } dps_rsp_t;

  typedef logic [7:0] dps_cfg_t;

  // one process table entry, 48 bits
  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] prio;
    logic [15:0]        cpu;
    logic [7:0]         need;
  } dps_entry_t;

endpackage
`default_nettype wire

// ----- hdl/dps_chan_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dps_chan_if: valid/ready channel
// Carries one payload of the given type from a source to a sink.
// ----------------------------------------------------------------------------
interface dps_chan_if #(
  parameter type payload_t = dps_pkg::dps_cfg_t
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

// ----- hdl/dynamic_priority_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler: dynamic priority process table
// Loads processes into a table and dispatches quanta to the entry with the
// highest priority, lowest id breaking ties, aging its priority each time.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload    | notes
//   ---------+-----+------------+---------------------------------------
//   in_ch    | in  | dps_req_t  | load or tick request
//   out_ch   | out | dps_rsp_t  | one result per request
//   cfg_ch   | in  | dps_cfg_t  | priority_step, always ready
//
// A request walks the table one slot a cycle through the single memory
// read port. A load stops at the first free slot, or at the last slot
// when the table is full. A tick reads every slot, then compares the last
// entry in S_LAST and writes the aged entry back in S_UPD.
// Reset clears the valid bits, the sequencer and the output register; the
// table memory itself is not cleared. The result register is separate from
// the sequencer, so a stalled result holds only the final hand-off.
//
`default_nettype none
module dynamic_priority_scheduler #(
  parameter int unsigned MAX_PROCS = dps_pkg::MAX_PROCS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dps_chan_if.sink    in_ch,
  dps_chan_if.source  out_ch,
  dps_chan_if.sink    cfg_ch
);

  localparam int unsigned IDX_W = $clog2(MAX_PROCS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  dps_pkg::dps_state_t  state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  dps_pkg::dps_req_t    req_r;
  logic [MAX_PROCS-1:0] valid_r, valid_nxt;
  logic [7:0]           step_r;

  // compare pipeline: slot read last cycle, data now in rd_data_r
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_slot_r;
  dps_pkg::dps_entry_t  rd_data_r;

  // current best candidate
  logic                 best_found_r, best_found_nxt;
  dps_pkg::dps_entry_t  best_r, best_nxt;
  logic [IDX_W-1:0]     best_slot_r, best_slot_nxt;

  // pending result and output register
  dps_pkg::dps_rsp_t    rsp_r, rsp_nxt;
  logic                 out_valid_r;
  dps_pkg::dps_rsp_t    out_data_r;

  // memory write port
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  dps_pkg::dps_entry_t  wr_data;

  logic                 in_fire;
  logic                 out_free;
  logic                 slot_free;

  // aging arithmetic
  logic signed [16:0]   prio_diff;
  logic signed [15:0]   prio_aged;
  logic [15:0]          cpu_aged;
  logic                 done_now;
  logic                 take;

  dps_pkg::dps_entry_t  table_mem [MAX_PROCS];

  assign in_ch.ready   = (state_r == dps_pkg::S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.payload = out_data_r;
  assign slot_free     = !valid_r[idx_r];

  // --------------------------------------------------------------------------
  // Shared compare unit: does the entry just read beat the current best?
  // Strictly better only, so the lowest slot wins a full tie.
  // --------------------------------------------------------------------------
  always_comb begin
    take = 1'b0;
    if (cmp_vld_r) begin
      if (!best_found_r) begin
        take = 1'b1;
      end else if ($signed(rd_data_r.prio) > $signed(best_r.prio)) begin
        take = 1'b1;
      end else if ((rd_data_r.prio == best_r.prio) && (rd_data_r.id < best_r.id)) begin
        take = 1'b1;
      end
    end
  end

  // aging of the chosen entry
  always_comb begin
    prio_diff = {best_r.prio[15], best_r.prio} - $signed({9'd0, step_r});
    // underflow past the floor shows as sign bits that disagree
    prio_aged = (prio_diff[16] != prio_diff[15]) ? 16'sh8000 : prio_diff[15:0];
    cpu_aged  = (best_r.cpu == 16'hFFFF) ? best_r.cpu : best_r.cpu + 16'd1;
    done_now  = (best_r.need <= 8'd1);
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dps_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = dps_pkg::S_SCAN;
        end
      end
      dps_pkg::S_SCAN: begin
        if (req_r.req_type == dps_pkg::REQ_LOAD) begin
          if (slot_free || (idx_r == LAST_IDX)) begin
            state_nxt = dps_pkg::S_RESP;
          end
        end else if (idx_r == LAST_IDX) begin
          state_nxt = dps_pkg::S_LAST;
        end
      end
      dps_pkg::S_LAST: state_nxt = dps_pkg::S_UPD;
      dps_pkg::S_UPD:  state_nxt = dps_pkg::S_RESP;
      dps_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = dps_pkg::S_IDLE;
        end
      end
      default: state_nxt = dps_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    idx_nxt        = idx_r;
    valid_nxt      = valid_r;
    cmp_vld_nxt    = 1'b0;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    best_slot_nxt  = best_slot_r;
    rsp_nxt        = rsp_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '{id: req_r.proc_id, prio: req_r.start_priority,
                       cpu: req_r.start_cpu_time, need: req_r.need_time};

    // fold the entry read last cycle into the best candidate
    if (take) begin
      best_found_nxt = 1'b1;
      best_nxt       = rd_data_r;
      best_slot_nxt  = cmp_slot_r;
    end

    unique case (state_r)
      dps_pkg::S_IDLE: begin
        idx_nxt        = '0;
        best_found_nxt = 1'b0;
      end
      dps_pkg::S_SCAN: begin
        if (req_r.req_type == dps_pkg::REQ_LOAD) begin
          rsp_nxt = '{status: dps_pkg::ST_FULL, run_id: req_r.proc_id,
                      new_priority: '0, new_cpu_time: '0, remaining: '0};
          if (slot_free) begin
            wr_en            = 1'b1;
            valid_nxt[idx_r] = 1'b1;
            rsp_nxt.status   = dps_pkg::ST_LOADED;
          end
        end else begin
          cmp_vld_nxt = valid_r[idx_r];
        end
        if (idx_r != LAST_IDX) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      dps_pkg::S_LAST: begin
      end
      dps_pkg::S_UPD: begin
        if (best_found_r) begin
          wr_en   = 1'b1;
          wr_addr = best_slot_r;
          wr_data = '{id: best_r.id, prio: prio_aged, cpu: cpu_aged,
                      need: done_now ? 8'd0 : best_r.need - 8'd1};
          if (done_now) begin
            valid_nxt[best_slot_r] = 1'b0;
          end
          rsp_nxt = '{status: done_now ? dps_pkg::ST_DONE : dps_pkg::ST_RUN,
                      run_id: best_r.id, new_priority: prio_aged,
                      new_cpu_time: cpu_aged, remaining: wr_data.need};
        end else begin
          rsp_nxt = '{status: dps_pkg::ST_IDLE, run_id: '0,
                      new_priority: '0, new_cpu_time: '0, remaining: '0};
        end
      end
      dps_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dps_pkg::S_IDLE;
      valid_r      <= '0;
      step_r       <= dps_pkg::PRIO_STEP_RST;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      best_found_r <= best_found_nxt;
      if (cfg_ch.valid) begin
        step_r <= cfg_ch.payload;
      end
      // hand the result over; drop it once taken
      if (state_r == dps_pkg::S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cmp_slot_r  <= idx_r;
    best_r      <= best_nxt;
    best_slot_r <= best_slot_nxt;
    rsp_r       <= rsp_nxt;
    if (in_fire) begin
      req_r <= in_ch.payload;
    end
    if (state_r == dps_pkg::S_RESP && out_free) begin
      out_data_r <= rsp_r;
    end
  end

  // process table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= table_mem[idx_r];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_rose_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == dps_pkg::S_RESP)
    else $error("result raised outside the hand-off state");

  a_best_is_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dps_pkg::S_UPD && best_found_r) |-> valid_r[best_slot_r])
    else $error("chosen slot is not a live entry");

  a_one_slot_change: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r ^ $past(valid_r)) <= 1))
    else $error("more than one table slot changed in a cycle");

  a_write_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == dps_pkg::S_SCAN || state_r == dps_pkg::S_UPD))
    else $error("table written outside scan or update");
`endif

endmodule
`default_nettype wire
